>>> rtl/tga_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tga_pkg: shared types and constants for the Targa stream decoder
// Result kinds, error codes, parser phases and the result record.
// ----------------------------------------------------------------------------
package tga_pkg;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_PIXEL  = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	localparam logic [1:0] ERR_TYPE  = 2'd0;
	localparam logic [1:0] ERR_DEPTH = 2'd1;
	localparam logic [1:0] ERR_MAP   = 2'd2;
	localparam logic [1:0] ERR_TRUNC = 2'd3;

	localparam logic [19:0] SKIP_MAX   = 20'hFFFFF;
	localparam int          QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_HEADER = 3'd1,
		PH_SKIP   = 3'd2,
		PH_PACKET = 3'd3,
		PH_PIXEL  = 3'd4,
		PH_CALC   = 3'd5
	} phase_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] width;
		logic [15:0] height;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [7:0]  run;
		logic        done;
		logic [1:0]  err;
	} result_t;

endpackage
`default_nettype wire

>>> rtl/tga_image_stream_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tga_image_stream_decoder: Targa byte stream to RGBA pixel runs
// Input beats carry one file byte with first/last marks; output beats carry
// a header report, one pixel colour with repeat count, or an error.
// Throughput: one byte per cycle while the queue has room, but none in the
// calc phase after the header's last byte (pixel count and skip length are
// formed there; in_ready is low). Each result enters the queue on the edge
// that accepts the byte causing it; the header report (or a truncation on
// the header's last byte) is issued from the calc phase instead.
// A two-entry queue sits between parser and output; in_ready drops when it
// is full, so a stalled receiver holds the input after two results. The
// calc phase also waits for a free queue slot.
// Reset clears the parser to idle and empties the queue; bytes arriving
// while idle without first_byte are dropped silently.
// ----------------------------------------------------------------------------
module tga_image_stream_decoder (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [7:0]  data_byte,
	input  wire         first_byte,
	input  wire         last_byte,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [1:0]  result_kind,
	output logic [15:0] image_width,
	output logic [15:0] image_height,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic [7:0]  run_length,
	output logic        image_done,
	output logic [1:0]  error_code
);
	import tga_pkg::*;

	logic    room, res_valid;
	result_t res, q;

	tga_parser u_parser (
		.clk, .arst_n, .in_valid, .in_ready, .data_byte, .first_byte,
		.last_byte, .room, .res_valid, .res
	);

	tga_queue u_queue (
		.clk, .arst_n, .wr_valid(res_valid), .wr_data(res), .room,
		.rd_valid(out_valid), .rd_ready(out_ready), .rd_data(q)
	);

	assign result_kind = q.kind;
	assign image_width = q.width;
	assign image_height = q.height;
	assign red = q.red;
	assign green = q.green;
	assign blue = q.blue;
	assign alpha = q.alpha;
	assign run_length = q.run;
	assign image_done = q.done;
	assign error_code = q.err;

endmodule
`default_nettype wire

>>> rtl/tga_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tga_parser: byte parser front end
// Walks the header, skip region and packets; emits one result record per
// byte that produces one. After the header the calc phase forms the pixel
// count and skip length from two combinational multiplies and registers them.
// ----------------------------------------------------------------------------
module tga_parser (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire  [7:0]           data_byte,
	input  wire                  first_byte,
	input  wire                  last_byte,
	input  wire                  room,
	output logic                 res_valid,
	output tga_pkg::result_t     res
);
	import tga_pkg::*;

	phase_t      phase_q, phase_d;
	logic [4:0]  hidx_q, hidx_d;
	logic [7:0]  idlen_q, idlen_d, maptype_q, maptype_d, imgtype_q, imgtype_d;
	logic [15:0] mapent_q, mapent_d, w_q, w_d, h_q, h_d;
	logic [7:0]  mapbits_q, mapbits_d, pbits_q, pbits_d;
	logic [19:0] skip_q, skip_d;
	logic [31:0] pix_q, pix_d;
	logic        isrun_q, isrun_d;
	logic [6:0]  raw_q, raw_d;
	logic [1:0]  bip_q, bip_d;
	logic [23:0] buf_q, buf_d;
	logic        last_q, last_d;

	logic        take;
	logic [31:0] area;
	logic [20:0] mapbytes;
	logic [21:0] skip_sum;
	logic [7:0]  bpe;
	logic        rle;
	logic [31:0] cnt;
	logic [7:0]  alpha_v;
	logic        px_done;
	logic        eff_first;

	assign rle = (imgtype_q == 8'd10);
	assign bpe = 8'((9'(mapbits_q) + 9'd7) >> 3);
	assign area = 32'(w_q) * 32'(h_q);
	// up to 32 bytes per map entry
	assign mapbytes = (maptype_q == 8'd1) ? 21'(mapent_q) * 21'(bpe) : 21'd0;
	assign skip_sum = 22'(idlen_q) + 22'(mapbytes);

	// calc phase owns the cycle; otherwise take a byte when a queue slot is free
	assign in_ready = room && (phase_q != PH_CALC);
	assign take = in_valid && in_ready;
	assign eff_first = first_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			hidx_q <= '0; idlen_q <= '0; maptype_q <= '0; imgtype_q <= '0;
			mapent_q <= '0; mapbits_q <= '0; w_q <= '0; h_q <= '0;
			pbits_q <= '0; skip_q <= '0; pix_q <= '0; isrun_q <= 1'b0;
			raw_q <= '0; bip_q <= '0; buf_q <= '0; last_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			hidx_q <= hidx_d; idlen_q <= idlen_d; maptype_q <= maptype_d;
			imgtype_q <= imgtype_d; mapent_q <= mapent_d; mapbits_q <= mapbits_d;
			w_q <= w_d; h_q <= h_d; pbits_q <= pbits_d; skip_q <= skip_d;
			pix_q <= pix_d; isrun_q <= isrun_d; raw_q <= raw_d; bip_q <= bip_d;
			buf_q <= buf_d; last_q <= last_d;
		end
	end

	always_comb begin
		phase_t ph;
		phase_d = phase_q; hidx_d = hidx_q; idlen_d = idlen_q;
		maptype_d = maptype_q; imgtype_d = imgtype_q; mapent_d = mapent_q;
		mapbits_d = mapbits_q; w_d = w_q; h_d = h_q; pbits_d = pbits_q;
		skip_d = skip_q; pix_d = pix_q; isrun_d = isrun_q; raw_d = raw_q;
		bip_d = bip_q; buf_d = buf_q; last_d = last_q;
		res_valid = 1'b0;
		res = '0;
		cnt = '0;
		alpha_v = 8'd255;
		px_done = 1'b0;
		ph = phase_q;

		if (phase_q == PH_CALC && room) begin
			// header fully in and checks passed; waits here for a queue slot
			pix_d = area;
			skip_d = (skip_sum > 22'(SKIP_MAX)) ? SKIP_MAX : skip_sum[19:0];
			res_valid = 1'b1;
			res.kind = KIND_HEADER;
			res.width = w_q;
			res.height = h_q;
			res.done = (area == 32'd0);
			bip_d = '0; raw_d = '0; isrun_d = 1'b0; buf_d = '0;
			if (area == 32'd0)
				ph = PH_IDLE;
			else if (skip_sum != 22'd0)
				ph = PH_SKIP;
			else
				ph = rle ? PH_PACKET : PH_PIXEL;
			if (last_q && ph != PH_IDLE) begin
				res.kind = KIND_ERROR; res.width = '0; res.height = '0;
				res.done = 1'b0; res.err = ERR_TRUNC;
				ph = PH_IDLE;
			end
			phase_d = ph;
		end else if (take) begin
			if (eff_first) begin
				ph = PH_HEADER;
				hidx_d = '0; idlen_d = '0; maptype_d = '0; imgtype_d = '0;
				mapent_d = '0; mapbits_d = '0; w_d = '0; h_d = '0; pbits_d = '0;
				skip_d = '0; pix_d = '0; isrun_d = 1'b0; raw_d = '0;
				bip_d = '0; buf_d = '0;
			end
			last_d = last_byte;
			case (ph)
				PH_HEADER: begin
					case (eff_first ? 5'd0 : hidx_q)
						5'd0:  idlen_d = data_byte;
						5'd1:  maptype_d = data_byte;
						5'd2:  imgtype_d = data_byte;
						5'd5:  mapent_d[7:0] = data_byte;
						5'd6:  mapent_d[15:8] = data_byte;
						5'd7:  mapbits_d = data_byte;
						5'd12: w_d[7:0] = data_byte;
						5'd13: w_d[15:8] = data_byte;
						5'd14: h_d[7:0] = data_byte;
						5'd15: h_d[15:8] = data_byte;
						5'd16: pbits_d = data_byte;
						default: ;
					endcase
					if (!eff_first && hidx_q >= 5'd17) begin
						if (imgtype_q != 8'd2 && imgtype_q != 8'd10) begin
							res_valid = 1'b1; res.kind = KIND_ERROR; res.err = ERR_TYPE;
							ph = PH_IDLE;
						end else if (pbits_q != 8'd24 && pbits_q != 8'd32) begin
							res_valid = 1'b1; res.kind = KIND_ERROR; res.err = ERR_DEPTH;
							ph = PH_IDLE;
						end else if (maptype_q > 8'd1) begin
							res_valid = 1'b1; res.kind = KIND_ERROR; res.err = ERR_MAP;
							ph = PH_IDLE;
						end else begin
							ph = PH_CALC;
						end
					end else begin
						hidx_d = (eff_first ? 5'd0 : hidx_q) + 5'd1;
					end
				end
				PH_SKIP: begin
					skip_d = skip_q - 20'd1;
					if (skip_q == 20'd1) begin
						bip_d = '0; raw_d = '0; isrun_d = 1'b0; buf_d = '0;
						ph = rle ? PH_PACKET : PH_PIXEL;
					end
				end
				PH_PACKET: begin
					isrun_d = data_byte[7];
					raw_d = data_byte[6:0];
					bip_d = '0;
					ph = PH_PIXEL;
				end
				PH_PIXEL: begin
					if (bip_q < 2'd3) begin
						buf_d = (bip_q == 2'd0) ? {16'd0, data_byte}
							: (bip_q == 2'd1) ? {buf_q[23:16], data_byte, buf_q[7:0]}
							: {data_byte, buf_q[15:0]};
						bip_d = bip_q + 2'd1;
						px_done = (bip_q == 2'd2) && (pbits_q != 8'd32);
					end else begin
						alpha_v = data_byte;
						px_done = 1'b1;
					end
					if (px_done) begin
						bip_d = '0;
						cnt = (rle && isrun_q) ? 32'(raw_q) + 32'd1 : 32'd1;
						if (cnt > pix_q) cnt = pix_q;
						pix_d = pix_q - cnt;
						res_valid = 1'b1;
						res.kind = KIND_PIXEL;
						res.red = buf_d[23:16];
						res.green = buf_d[15:8];
						res.blue = buf_d[7:0];
						res.alpha = alpha_v;
						res.run = cnt[7:0];
						res.done = (pix_d == 32'd0);
						if (pix_d == 32'd0)
							ph = PH_IDLE;
						else if (rle) begin
							if (isrun_q || raw_q == 7'd0)
								ph = PH_PACKET;
							else
								raw_d = raw_q - 7'd1;
						end
					end
				end
				default: ;
			endcase
			// truncation; PH_CALC defers the check to its own cycle
			if (last_byte && ph != PH_IDLE && ph != PH_CALC) begin
				res_valid = 1'b1;
				res = '0;
				res.kind = KIND_ERROR;
				res.err = ERR_TRUNC;
				ph = PH_IDLE;
			end
			phase_d = ph;
		end
	end

	a_no_take_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		!(phase_q == PH_CALC && take))
		else $error("byte taken during calc cycle");
	a_res_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_valid && !room))
		else $error("result issued with queue full");
	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		!(phase_q == PH_SKIP && skip_q == 20'd0))
		else $error("skip phase with zero count");

endmodule
`default_nettype wire

>>> rtl/tga_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tga_queue: short result queue between parser and output port
// Two-entry FIFO; room is the not-full flag decoded from the registered count.
// ----------------------------------------------------------------------------
module tga_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  wr_valid,
	input  tga_pkg::result_t     wr_data,
	output logic                 room,
	output logic                 rd_valid,
	input  wire                  rd_ready,
	output tga_pkg::result_t     rd_data
);
	import tga_pkg::*;

	result_t    mem_q [QUEUE_DEPTH];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign room = (cnt_q != 2'(QUEUE_DEPTH));
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && room;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(QUEUE_DEPTH))
		else $error("queue overflow");
	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_valid && !room))
		else $error("write offered while queue full");
	a_head_known: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid |-> !$isunknown(rd_data))
		else $error("queue head unknown while valid");

endmodule
`default_nettype wire

>>> tb/tga_decode_checker.sv
// ----------------------------------------------------------------------------
// tga_decode_checker: predicts Targa decoder results and checks output beats
// Watches accepted input beats, runs a parser model in step with the byte
// stream, queues the expected results and compares each output beat field by
// field with the oldest one.
// ----------------------------------------------------------------------------
module tga_decode_checker
	import tga_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	input  wire         in_ready,
	input  wire  [7:0]  data_byte,
	input  wire         first_byte,
	input  wire         last_byte,
	input  wire         out_valid,
	input  wire         out_ready,
	input  wire  [1:0]  result_kind,
	input  wire  [15:0] image_width,
	input  wire  [15:0] image_height,
	input  wire  [7:0]  red,
	input  wire  [7:0]  green,
	input  wire  [7:0]  blue,
	input  wire  [7:0]  alpha,
	input  wire  [7:0]  run_length,
	input  wire         image_done,
	input  wire  [1:0]  error_code,
	output int          fail_count,
	output int          pending_results
);
	timeunit 1ns;
	timeprecision 1ps;

	result_t pending_q[$];

	phase_t      ph;
	logic [4:0]  hdr_idx;
	logic [7:0]  id_len, cmap_type, img_type, cmap_bits, depth, pkt_hdr;
	logic [15:0] cmap_len, img_w, img_h;
	logic [19:0] skip_cnt;
	logic [31:0] pix_left;
	logic [6:0]  raw_cnt;
	logic [1:0]  pix_byte;
	logic [23:0] pix_buf;

	function automatic result_t make_result(logic [1:0] k, logic [1:0] e);
		result_t r;
		r = '0;
		r.kind = k;
		r.err = e;
		return r;
	endfunction

	function automatic void start_pixels();
		pkt_hdr = 0;
		raw_cnt = 0;
		pix_byte = 0;
		pix_buf = 0;
		ph = (img_type == 8'd10) ? PH_PACKET : PH_PIXEL;
	endfunction

	// returns 1 when the byte produces a result in r
	function automatic bit decode_byte(logic [7:0] b, bit first, bit last, output result_t r);
		bit got;
		bit is_run;
		logic [31:0] skip_sum, cnt;
		logic [7:0] a;
		got = 0;
		r = '0;
		if (first) begin
			hdr_idx = 0; id_len = 0; cmap_type = 0; img_type = 0; cmap_len = 0;
			cmap_bits = 0; img_w = 0; img_h = 0; depth = 0; skip_cnt = 0;
			pix_left = 0; pkt_hdr = 0; raw_cnt = 0; pix_byte = 0; pix_buf = 0;
			ph = PH_HEADER;
		end
		case (ph)
			PH_HEADER: begin
				case (hdr_idx)
					0: id_len = b;
					1: cmap_type = b;
					2: img_type = b;
					5: cmap_len[7:0] = b;
					6: cmap_len[15:8] = b;
					7: cmap_bits = b;
					12: img_w[7:0] = b;
					13: img_w[15:8] = b;
					14: img_h[7:0] = b;
					15: img_h[15:8] = b;
					16: depth = b;
					default: ;
				endcase
				if (hdr_idx >= 17) begin
					got = 1;
					ph = PH_IDLE;
					if (img_type != 8'd2 && img_type != 8'd10)
						r = make_result(KIND_ERROR, ERR_TYPE);
					else if (depth != 8'd24 && depth != 8'd32)
						r = make_result(KIND_ERROR, ERR_DEPTH);
					else if (cmap_type > 1)
						r = make_result(KIND_ERROR, ERR_MAP);
					else begin
						pix_left = 32'(img_w) * 32'(img_h);
						skip_sum = 32'(id_len);
						if (cmap_type == 1)
							skip_sum += 32'(cmap_len) * ((32'(cmap_bits) + 7) >> 3);
						skip_cnt = (skip_sum > 32'(SKIP_MAX)) ? SKIP_MAX : skip_sum[19:0];
						r = make_result(KIND_HEADER, '0);
						r.width = img_w;
						r.height = img_h;
						r.done = (pix_left == 0);
						if (pix_left == 0)
							ph = PH_IDLE;
						else if (skip_cnt != 0)
							ph = PH_SKIP;
						else
							start_pixels();
					end
				end else begin
					hdr_idx++;
				end
			end
			PH_SKIP: begin
				skip_cnt--;
				if (skip_cnt == 0)
					start_pixels();
			end
			PH_PACKET: begin
				pkt_hdr = b;
				raw_cnt = b[6:0];
				pix_byte = 0;
				ph = PH_PIXEL;
			end
			PH_PIXEL: begin
				a = 8'd255;
				if (pix_byte < 3) begin
					if (pix_byte == 0)
						pix_buf = 0;
					pix_buf[8*pix_byte +: 8] = b;
					pix_byte++;
				end else begin
					a = b;
					pix_byte = 0;
				end
				if (pix_byte == 0 || (pix_byte == 3 && depth != 8'd32)) begin
					pix_byte = 0;
					is_run = (img_type == 8'd10) && pkt_hdr[7];
					cnt = is_run ? 32'(raw_cnt) + 1 : 1;
					if (cnt > pix_left)
						cnt = pix_left;
					pix_left -= cnt;
					r = make_result(KIND_PIXEL, '0);
					r.red = pix_buf[23:16];
					r.green = pix_buf[15:8];
					r.blue = pix_buf[7:0];
					r.alpha = a;
					r.run = cnt[7:0];
					r.done = (pix_left == 0);
					got = 1;
					if (pix_left == 0)
						ph = PH_IDLE;
					else if (img_type == 8'd10) begin
						if (is_run || raw_cnt == 0)
							ph = PH_PACKET;
						else
							raw_cnt--;
					end
				end
			end
			default: ;
		endcase
		if (last && ph != PH_IDLE) begin
			r = make_result(KIND_ERROR, ERR_TRUNC);
			ph = PH_IDLE;
			got = 1;
		end
		return got;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t r;
		result_t e;
		if (!arst_n) begin
			ph = PH_IDLE;
			hdr_idx = 0; id_len = 0; cmap_type = 0; img_type = 0; cmap_len = 0;
			cmap_bits = 0; img_w = 0; img_h = 0; depth = 0; skip_cnt = 0;
			pix_left = 0; pkt_hdr = 0; raw_cnt = 0; pix_byte = 0; pix_buf = 0;
			pending_q.delete();
			pending_results = 0;
			fail_count = 0;
		end else begin
			if (in_valid && in_ready)
				if (decode_byte(data_byte, first_byte, last_byte, r))
					pending_q.push_back(r);
			if (out_valid && out_ready) begin
				if (pending_q.size() == 0) begin
					$error("unexpected result beat, kind %0d", result_kind);
					fail_count++;
				end else begin
					e = pending_q.pop_front();
					check_field("result_kind", e.kind, result_kind);
					check_field("image_width", e.width, image_width);
					check_field("image_height", e.height, image_height);
					check_field("red", e.red, red);
					check_field("green", e.green, green);
					check_field("blue", e.blue, blue);
					check_field("alpha", e.alpha, alpha);
					check_field("run_length", e.run, run_length);
					check_field("image_done", e.done, image_done);
					check_field("error_code", e.err, error_code);
				end
			end
			pending_results = pending_q.size();
		end
	end

endmodule

>>> tb/tb_tga_image_stream_decoder.sv
// ----------------------------------------------------------------------------
// tb_tga_image_stream_decoder: stimulus and verdict for the Targa decoder
// Feeds directed header corner cases, then random well-formed Targa files
// (raw and run-length, 24/32 bit, ID and colour-map skips), truncated files
// and noise, under varying sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_tga_image_stream_decoder;
	timeunit 1ns;
	timeprecision 1ps;
	import tga_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic [7:0]  data_byte = 0;
	logic        first_byte = 0;
	logic        last_byte = 0;
	logic        out_ready = 0;
	wire         in_ready, out_valid, image_done;
	wire  [1:0]  result_kind, error_code;
	wire  [15:0] image_width, image_height;
	wire  [7:0]  red, green, blue, alpha, run_length;
	int          fail_count, pending_results;

	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	bit          recv_hold = 0;
	int          beats_sent = 0;

	tga_image_stream_decoder dut (.*);

	tga_decode_checker chk (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	always @(negedge clk)
		out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);

	initial begin
		#50ms;
		$display("CHECKS FAILED");
		$finish;
	end

	// one beat; idles before it as the current pct says. valid stays up after
	// the beat; an idle in the next call or drain() takes it down
	task automatic send_byte(logic [7:0] b, bit first = 0, bit last = 0);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		data_byte <= b;
		first_byte <= first;
		last_byte <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic send_header(logic [7:0] idl, logic [7:0] mt, logic [7:0] it,
			logic [15:0] ml, logic [7:0] mb, logic [15:0] w, logic [15:0] h,
			logic [7:0] d, bit last = 0);
		logic [7:0] hdr[18];
		for (int i = 0; i < 18; i++)
			hdr[i] = $urandom_range(255);
		hdr[0] = idl; hdr[1] = mt; hdr[2] = it;
		hdr[5] = ml[7:0]; hdr[6] = ml[15:8]; hdr[7] = mb;
		hdr[12] = w[7:0]; hdr[13] = w[15:8]; hdr[14] = h[7:0]; hdr[15] = h[15:8];
		hdr[16] = d;
		for (int i = 0; i < 18; i++)
			send_byte(hdr[i], i == 0, last && i == 17);
	endtask

	task automatic send_pixel(int bytes, bit last = 0);
		for (int i = 0; i < bytes; i++)
			send_byte($urandom_range(255), 0, last && i == bytes - 1);
	endtask

	// random valid file; cut > 1 ends it after that many body bytes, cut == 1 on the header's last byte
	task automatic send_file(int cut);
		logic [7:0] it, d, mt, idl, mb;
		logic [15:0] w, h, ml;
		int left, n, bpp, skip, sent;
		bit run;
		it = $urandom_range(1) ? 8'd10 : 8'd2;
		d = $urandom_range(1) ? 8'd32 : 8'd24;
		bpp = d / 8;
		mt = $urandom_range(1);
		idl = ($urandom_range(3) == 0) ? $urandom_range(6) : 0;
		ml = $urandom_range(3);
		mb = $urandom_range(1) ? 8'd8 : $urandom_range(255);
		w = $urandom_range(1, 6);
		h = $urandom_range(1, 4);
		if ($urandom_range(15) == 0) begin
			w = 16'hFFFF;
			h = 16'hFFFF;
		end
		skip = idl + (mt == 1 ? ml * ((mb + 7) / 8) : 0);
		send_header(idl, mt, it, ml, mb, w, h, d, cut == 1);
		if (cut == 1)
			return;
		sent = 0;
		for (int i = 0; i < skip; i++) begin
			sent++;
			send_byte($urandom_range(255), 0, sent == cut);
			if (sent == cut)
				return;
		end
		left = (w * h > 200) ? 40 : w * h;
		while (left > 0) begin
			if (it == 8'd2) begin
				n = 1;
				run = 0;
			end else begin
				run = $urandom_range(1);
				n = $urandom_range(1, 8);
				if ($urandom_range(9) == 0)
					n = 128;
				sent++;
				send_byte({run, 7'(n - 1)}, 0, sent == cut);
				if (sent == cut)
					return;
			end
			for (int p = 0; p < (run ? 1 : n) && left > 0; p++) begin
				for (int k = 0; k < bpp; k++) begin
					sent++;
					send_byte($urandom_range(255), 0, sent == cut);
					if (sent == cut)
						return;
				end
				if (!run)
					left--;
			end
			if (run)
				left -= n;
		end
		// huge images are cut off with a truncation
		if (w * h > 200)
			send_byte($urandom_range(255), 0, 1);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending_results != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		int stage;
		stage = 0;
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		send_idle_pct = 20;
		recv_idle_pct = 78;
		// ignored while idle
		send_byte(8'h00);
		send_byte(8'hFF, 0, 1);
		// header errors in check order, and on the last byte
		send_header(0, 2, 3, 0, 0, 1, 1, 24);
		send_header(0, 2, 2, 0, 0, 1, 1, 16);
		send_header(0, 7, 10, 0, 0, 1, 1, 32, 1);
		send_header(0, 1, 2, 0, 0, 1, 1, 24, 1);
		// empty image with a saturating skip length
		send_header(8'hFF, 8'h01, 8'd10, 16'hFFFF, 8'hFF, 0, 16'hFFFF, 32);
		send_header(0, 0, 2, 0, 0, 1, 1, 24);
		send_byte(8'h00); send_byte(8'hFF); send_byte(8'h80);
		send_header(0, 0, 10, 0, 0, 3, 1, 32);
		send_byte(8'hFF); send_pixel(4);
		drain();
		while (beats_sent < 700) begin
			if (stage == 0 && beats_sent >= 300) begin
				drain();
				send_idle_pct = 78;
				recv_idle_pct = 20;
				stage = 1;
			end
			if (stage == 1 && beats_sent >= 420) begin
				fork
					begin
						recv_hold = 1;
						repeat (200) @(posedge clk);
						recv_hold = 0;
					end
					begin
						send_file(0);
						drain();
					end
				join
				stage = 2;
			end
			if (stage == 2 && beats_sent >= 520) begin
				drain();
				send_idle_pct = 0;
				recv_idle_pct = 0;
				stage = 3;
			end
			case ($urandom_range(9))
				0: send_file($urandom_range(1, 12));
				1: repeat ($urandom_range(1, 5))
					send_byte($urandom_range(255), 0, $urandom_range(1));
				default: send_file(0);
			endcase
		end
		drain();
		repeat (10) @(negedge clk);
		if (fail_count == 0 && pending_results == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
